FILE: rtl/rfbd_pkg.sv
// Shared types and constants of the redundant frame bundle deframer.
package rfbd_pkg;

  // Bundle format
  localparam logic [7:0] HdrMagic   = 8'h4f;
  localparam logic [7:0] HdrVersion = 8'h01;
  localparam int         HdrBytes   = 6;
  localparam int         DescBytes  = 10;

  // Field widths
  localparam int SeqW   = 32;
  localparam int TsW    = 32;
  localparam int SizeW  = 16;
  localparam int IndexW = 3;
  localparam int LimitW = 3;

  // One descriptor as stored: sequence, timestamp, size (big-endian order)
  localparam int DescW  = SeqW + TsW + SizeW;

  // Bundle verdict codes
  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StHeader      = 3'd1,
    StRepairCount = 3'd2,
    StDescTrunc   = 3'd3,
    StPrimary     = 3'd4,
    StRepair      = 3'd5
  } status_e;

  // One input request
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            last;
    logic [SeqW-1:0] primary_seq;
    logic [TsW-1:0]  primary_ts;
  } rfbd_in_t;

  // One result request
  typedef struct packed {
    logic              has_byte;
    logic [IndexW-1:0] frame_index;
    logic              frame_first;
    logic              frame_last;
    logic [SeqW-1:0]   frame_seq;
    logic [TsW-1:0]    frame_ts;
    logic [SizeW-1:0]  frame_size;
    logic [7:0]        data_out;
    logic              is_end;
    status_e           status;
  } rfbd_res_t;

  // Handshake between the input register, the core and the result register
  typedef struct packed {
    logic take;      // core consumes the held input request this cycle
    logic res_valid; // core hands a result to the result register
  } rfbd_ctrl_t;

endpackage

FILE: rtl/rfbd_in_reg.sv
// Input register: holds one accepted request until the core takes it.
module rfbd_in_reg
  import rfbd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  rfbd_in_t item_i,
  input  logic     take_i,
  output logic     valid_o,
  output rfbd_in_t item_o
);

  logic     valid_q, valid_d;
  rfbd_in_t item_q;

  // Free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/rfbd_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module rfbd_out_reg
  import rfbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  rfbd_res_t res_i,
  output logic      free_o,
  output logic      valid_o,
  input  logic      ready_i,
  output rfbd_res_t res_o
);

  logic      valid_q, valid_d;
  rfbd_res_t res_q;

  // A new result may land when empty or when the held one leaves now
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/rfbd_core.sv
// Deframer core: bundle parse state, descriptor store and result build.
module rfbd_core
  import rfbd_pkg::*;
#(
  parameter int MAX_REPAIRS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_valid_i,
  input  logic              cfg_addr_i,
  input  logic [SizeW-1:0]  cfg_data_i,
  // held input request
  input  logic              in_valid_i,
  input  rfbd_in_t          in_item_i,
  // result side
  input  logic              out_free_i,
  output rfbd_ctrl_t        ctrl_o,
  output rfbd_res_t         res_o
);

  // Repair limit and frame index are 3 bits wide, so no more than this many
  // descriptors can ever be stored.
  localparam int MaxIndex = 2**IndexW - 1;
  localparam int Depth    = (MAX_REPAIRS > MaxIndex) ? MaxIndex : MAX_REPAIRS;
  localparam int IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int AsmW     = DescW - 8;

  localparam logic [3:0] HdrLastPos  = 4'(HdrBytes - 1);
  localparam logic [3:0] DescLastPos = 4'(DescBytes - 1);

  typedef enum logic [2:0] {
    PhHeader,
    PhDesc,
    PhPrimary,
    PhRepair,
    PhTrail,
    PhError
  } phase_e;

  // Configuration registers
  localparam logic CfgRepairLimit = 1'b0;
  localparam logic CfgMaxFrame    = 1'b1;

  logic [LimitW-1:0] repair_limit_q;
  logic [SizeW-1:0]  max_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repair_limit_q <= LimitW'(4);
      max_frame_q    <= SizeW'(1275);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgRepairLimit: repair_limit_q <= cfg_data_i[LimitW-1:0];
        CfgMaxFrame:    max_frame_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse state
  phase_e            phase_q, phase_d;
  logic [3:0]        pos_q, pos_d;
  logic [IndexW-1:0] desc_idx_q, desc_idx_d;
  logic [7:0]        repair_total_q, repair_total_d;
  logic [SizeW-1:0]  plen_q, plen_d;
  logic [SeqW-1:0]   held_seq_q, held_seq_d;
  logic [TsW-1:0]    held_ts_q, held_ts_d;
  logic [IndexW-1:0] cur_frame_q, cur_frame_d;
  logic [SizeW-1:0]  bytes_left_q, bytes_left_d;
  status_e           first_error_q, first_error_d;
  // tags of the frame being streamed
  logic [SeqW-1:0]   cur_seq_q, cur_seq_d;
  logic [TsW-1:0]    cur_ts_q, cur_ts_d;
  logic [SizeW-1:0]  cur_size_q, cur_size_d;
  // descriptor assembly and store
  logic [AsmW-1:0]   asm_q, asm_d;
  logic [DescW-1:0]  desc_q [Depth];
  logic              desc_we;
  logic [DescW-1:0]  desc_wdata;
  // stored entry of the repair frame that follows the current one
  logic [DescW-1:0]  upcoming_desc_q;
  logic [IdxW-1:0]   rd_idx;

  rfbd_in_t          item;
  rfbd_res_t         res;
  logic              take;
  logic              emit;
  logic [7:0]        lim;
  logic [SizeW-1:0]  plen_new;
  logic [SizeW-1:0]  left_next;
  logic [SizeW-1:0]  upcoming_size;

  assign item = in_item_i;
  assign take = in_valid_i && out_free_i;

  // Repair limit beyond the store acts as the store size
  assign lim = (int'(repair_limit_q) > MAX_REPAIRS) ? 8'(MAX_REPAIRS)
                                                     : 8'(repair_limit_q);

  assign plen_new      = {plen_q[15:8], item.data_byte};
  assign left_next     = (bytes_left_q == '0) ? '0 : bytes_left_q - 1'b1;
  assign upcoming_size = upcoming_desc_q[SizeW-1:0];
  assign desc_wdata    = {asm_q, item.data_byte};
  assign rd_idx        = cur_frame_d[IdxW-1:0];

  function automatic logic size_ok(logic [SizeW-1:0] sz, logic [SizeW-1:0] mx);
    return (sz != '0) && (sz <= mx);
  endfunction

  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    desc_idx_d     = desc_idx_q;
    repair_total_d = repair_total_q;
    plen_d         = plen_q;
    held_seq_d     = held_seq_q;
    held_ts_d      = held_ts_q;
    cur_frame_d    = cur_frame_q;
    bytes_left_d   = bytes_left_q;
    first_error_d  = first_error_q;
    cur_seq_d      = cur_seq_q;
    cur_ts_d       = cur_ts_q;
    cur_size_d     = cur_size_q;
    asm_d          = asm_q;
    desc_we        = 1'b0;
    emit           = 1'b0;
    res            = '0;

    if (take) begin
      // primary tags ride on the first byte of a bundle
      if (phase_q == PhHeader && pos_q == '0) begin
        held_seq_d = item.primary_seq;
        held_ts_d  = item.primary_ts;
      end

      case (phase_q)
        PhHeader: begin
          pos_d = pos_q + 1'b1;
          if (pos_q == 4'd0 && item.data_byte != HdrMagic) begin
            first_error_d = StHeader;
            phase_d       = PhError;
          end else if (pos_q == 4'd1 && item.data_byte != HdrVersion) begin
            first_error_d = StHeader;
            phase_d       = PhError;
          end else if (pos_q == 4'd2) begin
            repair_total_d = item.data_byte;
          end else if (pos_q == 4'd4) begin
            plen_d = {item.data_byte, 8'h00};
          end else if (pos_q == HdrLastPos) begin
            plen_d = plen_new;
            if (repair_total_q > lim) begin
              first_error_d = StRepairCount;
              phase_d       = PhError;
            end else if (repair_total_q == '0) begin
              if (!size_ok(plen_new, max_frame_q)) begin
                first_error_d = StPrimary;
                phase_d       = PhError;
              end else begin
                phase_d      = PhPrimary;
                cur_frame_d  = '0;
                bytes_left_d = plen_new;
                cur_seq_d    = held_seq_q;
                cur_ts_d     = held_ts_q;
                cur_size_d   = plen_new;
              end
            end else begin
              phase_d    = PhDesc;
              pos_d      = '0;
              desc_idx_d = '0;
            end
          end
        end

        PhDesc: begin
          // shift bytes in; the tenth byte completes an entry
          asm_d = {asm_q[AsmW-9:0], item.data_byte};
          pos_d = pos_q + 1'b1;
          if (pos_q == DescLastPos) begin
            pos_d      = '0;
            desc_we    = 1'b1;
            desc_idx_d = desc_idx_q + 1'b1;
            if (8'(desc_idx_q + 1'b1) == repair_total_q) begin
              if (!size_ok(plen_q, max_frame_q)) begin
                first_error_d = StPrimary;
                phase_d       = PhError;
              end else begin
                phase_d      = PhPrimary;
                cur_frame_d  = '0;
                bytes_left_d = plen_q;
                cur_seq_d    = held_seq_q;
                cur_ts_d     = held_ts_q;
                cur_size_d   = plen_q;
              end
            end
          end
        end

        PhPrimary, PhRepair: begin
          emit            = 1'b1;
          res.has_byte    = 1'b1;
          res.frame_index = cur_frame_q;
          res.frame_first = (bytes_left_q == cur_size_q);
          res.frame_last  = (bytes_left_q == SizeW'(1));
          res.frame_seq   = cur_seq_q;
          res.frame_ts    = cur_ts_q;
          res.frame_size  = cur_size_q;
          res.data_out    = item.data_byte;
          bytes_left_d    = left_next;
          // frame done: open the next repair frame or go to trailer
          if (left_next == '0) begin
            if (8'(cur_frame_q) < repair_total_q) begin
              if (!size_ok(upcoming_size, max_frame_q)) begin
                first_error_d = StRepair;
                phase_d       = PhError;
              end else begin
                cur_frame_d  = cur_frame_q + 1'b1;
                phase_d      = PhRepair;
                bytes_left_d = upcoming_size;
                cur_seq_d    = upcoming_desc_q[DescW-1 -: SeqW];
                cur_ts_d     = upcoming_desc_q[SizeW +: TsW];
                cur_size_d   = upcoming_size;
              end
            end else begin
              phase_d = PhTrail;
            end
          end
        end

        default: ;
      endcase

      // verdict on the final byte, then back to a fresh bundle
      if (item.last) begin
        res.is_end = 1'b1;
        if (first_error_d != StOk) begin
          res.status = first_error_d;
        end else begin
          case (phase_d)
            PhHeader:  res.status = StHeader;
            PhDesc:    res.status = StDescTrunc;
            PhPrimary: res.status = StPrimary;
            PhRepair:  res.status = StRepair;
            default:   res.status = StOk;
          endcase
        end
        phase_d        = PhHeader;
        pos_d          = '0;
        desc_idx_d     = '0;
        repair_total_d = '0;
        plen_d         = '0;
        cur_frame_d    = '0;
        bytes_left_d   = '0;
        first_error_d  = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHeader;
      pos_q          <= '0;
      desc_idx_q     <= '0;
      repair_total_q <= '0;
      plen_q         <= '0;
      held_seq_q     <= '0;
      held_ts_q      <= '0;
      cur_frame_q    <= '0;
      bytes_left_q   <= '0;
      first_error_q  <= StOk;
    end else begin
      phase_q        <= phase_d;
      pos_q          <= pos_d;
      desc_idx_q     <= desc_idx_d;
      repair_total_q <= repair_total_d;
      plen_q         <= plen_d;
      held_seq_q     <= held_seq_d;
      held_ts_q      <= held_ts_d;
      cur_frame_q    <= cur_frame_d;
      bytes_left_q   <= bytes_left_d;
      first_error_q  <= first_error_d;
    end
  end

  // Frame tags and descriptor data, no reset
  always_ff @(posedge clk_i) begin
    cur_seq_q  <= cur_seq_d;
    cur_ts_q   <= cur_ts_d;
    cur_size_q <= cur_size_d;
    asm_q      <= asm_d;
    if (desc_we) begin
      desc_q[desc_idx_q[IdxW-1:0]] <= desc_wdata;
    end
    // registered read of the entry at the next frame index, with write-through
    if (desc_we && desc_idx_q[IdxW-1:0] == rd_idx) begin
      upcoming_desc_q <= desc_wdata;
    end else begin
      upcoming_desc_q <= desc_q[rd_idx];
    end
  end

  assign ctrl_o.take      = take;
  assign ctrl_o.res_valid = take && (emit || item.last);
  assign res_o            = res;

endmodule

FILE: rtl/redundant_frame_bundle_deframer_unit.sv
// Top level of the redundant frame bundle deframer.
// Takes a bundle one byte per request (tlast on the final byte), checks the
// 6-byte header, stores up to the repair limit (no more than MAX_REPAIRS or 7)
// 10-byte repair descriptors and then streams the primary and repair payload
// bytes out, each tagged with frame index, first/last marks, sequence,
// timestamp and size. Header, descriptor and trailing bytes give no result
// except the final byte, whose result carries tlast and the bundle verdict; a
// non-zero verdict means all bytes already sent for that bundle must be dropped.
// One byte can be accepted in every clock cycle without gaps while the result
// side keeps up: the held input request is parsed by combinational counter,
// compare and descriptor-select logic, and a result is presented by the result
// register after its byte has passed through the input register. A result held
// by a stalled result side blocks the next byte. No clearing pass after reset.
// Configuration is to be written by the user through the cfg port (index 0: repair
// limit, index 1: largest frame size) only while idle; the block does not enforce it.
module redundant_frame_bundle_deframer_unit
  import rfbd_pkg::*;
#(
  parameter int MAX_REPAIRS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // data_byte[7:0], primary_seq[39:8], primary_ts[71:40]
  input  logic        s_axis_tlast_i,  // last
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // frame_seq[31:0], frame_ts[63:32],
                                       // frame_size[79:64], data_out[87:80],
                                       // status[90:88], zero[95:91]
  output logic [5:0]  m_axis_tuser_o,  // has_byte[0], frame_index[3:1],
                                       // frame_first[4], frame_last[5]
  output logic        m_axis_tlast_o,  // is_end
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  rfbd_in_t   s_item;
  rfbd_in_t   in_item;
  logic       in_valid;
  rfbd_ctrl_t ctrl;
  rfbd_res_t  core_res;
  rfbd_res_t  out_res;
  logic       out_free;

  // Unpack the input request
  assign s_item.data_byte   = s_axis_tdata_i[7:0];
  assign s_item.last        = s_axis_tlast_i;
  assign s_item.primary_seq = s_axis_tdata_i[39:8];
  assign s_item.primary_ts  = s_axis_tdata_i[71:40];

  assign cfg_ready_o = 1'b1;

  rfbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (s_item),
    .take_i  (ctrl.take),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  rfbd_core #(
    .MAX_REPAIRS (MAX_REPAIRS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .res_o       (core_res)
  );

  rfbd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctrl.res_valid),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  // Pack the result request
  assign m_axis_tdata_o = {5'b0, out_res.status, out_res.data_out, out_res.frame_size,
                           out_res.frame_ts, out_res.frame_seq};
  assign m_axis_tuser_o = {out_res.frame_last, out_res.frame_first,
                           out_res.frame_index, out_res.has_byte};
  assign m_axis_tlast_o = out_res.is_end;

endmodule
